// File: hw/rtl/voice_slot_allocator_assert.svh
// assertion macros for the voice slot allocator
// used by the top level, no other dependencies
`ifndef VOICE_SLOT_ALLOCATOR_ASSERT_SVH
`define VOICE_SLOT_ALLOCATOR_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define VSA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// implication with the consequent checked in the following cycle
`define VSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/vsa_pkg.sv
// shared types and constants for the voice slot allocator
// no dependencies
`default_nettype none
package vsa_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int VSLOTS_DEF = 16;
  localparam logic [15:0] UNITY = 16'h8000;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0, CMD_ALLOC = 3'd1, CMD_FREE = 3'd2, CMD_FREE_VIRT = 3'd3,
    CMD_FIND = 3'd4, CMD_REACT = 3'd5, CMD_SET = 3'd6, CMD_NONE = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_FREE_SLOT = 3'd0, ST_VIRTUALIZED = 3'd1, ST_STOLEN = 3'd2, ST_ALL_PROT = 3'd3,
    ST_FOUND = 3'd4, ST_NOT_FOUND = 3'd5, ST_DONE = 3'd6, ST_NO_FREE = 3'd7
  } status_t;

  localparam logic [1:0] CFG_MAX_VOICES = 2'd0;
  localparam logic [1:0] CFG_MAX_VIRT = 2'd1;
  localparam logic [1:0] CFG_THRESH = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_REAL, S_SCAN_VIRT, S_SCAN_QUIET, S_MUL, S_SCAN_OLD, S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] voice_id;
    logic [15:0] new_volume;
    logic [15:0] new_gain;
    logic        new_protect;
    logic        new_spatial;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [31:0] result_id;
    logic [31:0] displaced_id;
    logic [15:0] found_volume;
    logic [15:0] found_gain;
    logic        found_protect;
    logic        found_spatial;
    logic        in_virtual;
  } out_item_t;

  function automatic logic [15:0] sat_q15(input logic [15:0] v);
    sat_q15 = (v > UNITY) ? UNITY : v;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/voice_slot_allocator.sv
// voice slot allocator top level: slot store, virtual pool, scan sequencer
// depends on vsa_pkg and voice_slot_allocator_assert.svh
//
// usage:
//   in channel (in_valid/in_ready/in_data) carries one command per transfer
//   out channel (out_valid/out_ready/out_data) returns exactly one result
//   per command; cfg_we/cfg_index/cfg_data write max_voices, max_virtual
//   and virtual_threshold while the block is idle
// timing:
//   one index is examined per cycle by a single shared compare unit;
//   a command walks the real slots and, where needed, the virtual pool
//   (free_virtual walks only the virtual pool), then for an allocate with
//   no free slot the quiet-voice scan, a multiply step and the
//   oldest-voice scan; clear and none go straight to the result, and
//   after the result transfers the block returns to idle
//   one command at a time: in_ready is low from acceptance until the
//   result transfers
// reset: all slots default, virtual pool empty, counters zero, no clearing
//   pass needed (state is in flip-flops)
// stall: the result is held in out_data until out_ready
`default_nettype none
`include "voice_slot_allocator_assert.svh"
module voice_slot_allocator
  import vsa_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int VIRTUAL_SLOTS = VSLOTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int VW = (VIRTUAL_SLOTS > 1) ? $clog2(VIRTUAL_SLOTS) : 1;
  localparam int CW = (SW > VW ? SW : VW) + 1;

  // configuration
  logic [4:0] max_voices, max_virtual;
  logic [15:0] virtual_threshold;

  // slot store
  logic [SLOTS-1:0] slot_active, slot_protect, slot_spatial;
  logic [31:0] slot_ident [SLOTS];
  logic [31:0] slot_age [SLOTS];
  logic [15:0] slot_volume [SLOTS];
  logic [15:0] slot_gain [SLOTS];
  // virtual pool
  logic [VIRTUAL_SLOTS-1:0] virt_valid;
  logic [31:0] virt_ident [VIRTUAL_SLOTS];
  logic [15:0] virt_volume [VIRTUAL_SLOTS];
  logic [15:0] virt_gain [VIRTUAL_SLOTS];
  logic [1:0]  virt_flags [VIRTUAL_SLOTS];
  logic [31:0] next_ident, age_clock;

  state_t state, state_next;
  in_item_t cur;
  logic [CW-1:0] idx;
  // scan results
  logic rhit, rfree, vhit, vfree, qhit, ohit;
  logic [SW-1:0] ridx, fidx, qidx, oidx;
  logic [VW-1:0] vidx, eidx;
  logic [15:0] qvol;
  logic [31:0] obest;
  logic [CW-1:0] vcount;
  logic [31:0] prod;

  // effective number of slots
  logic [CW:0] nused, vcap;
  assign nused = (int'(max_voices) > SLOTS) ? (CW+1)'(SLOTS) : (CW+1)'(max_voices);
  assign vcap = (int'(max_virtual) > VIRTUAL_SLOTS) ? (CW+1)'(VIRTUAL_SLOTS)
                                                     : (CW+1)'(max_virtual);

  logic [SW-1:0] si;
  logic [VW-1:0] vi;
  assign si = idx[SW-1:0];
  assign vi = idx[VW-1:0];
  logic last_real, last_virt;
  assign last_real = (idx == CW'(SLOTS - 1));
  assign last_virt = (idx == CW'(VIRTUAL_SLOTS - 1));
  logic in_use;
  assign in_use = ({1'b0, idx} < nused);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        state_next = (in_data.cmd == CMD_CLEAR || in_data.cmd == CMD_NONE) ? S_OUT :
                     (in_data.cmd == CMD_FREE_VIRT) ? S_SCAN_VIRT : S_SCAN_REAL;
      end
      S_SCAN_REAL: if (last_real) begin
        case (cur.cmd)
          CMD_ALLOC: state_next = S_SCAN_VIRT;
          CMD_FREE:  state_next = S_OUT;
          CMD_FIND, CMD_SET: state_next = S_SCAN_VIRT;
          CMD_REACT: state_next = S_SCAN_VIRT;
          default:   state_next = S_OUT;
        endcase
      end
      S_SCAN_VIRT: if (last_virt) begin
        state_next = S_OUT;
        if (cur.cmd == CMD_ALLOC && !rfree) state_next = S_SCAN_QUIET;
      end
      S_SCAN_QUIET: if (last_real) state_next = S_MUL;
      S_MUL: state_next = S_SCAN_OLD;
      S_SCAN_OLD: if (last_real) state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready = (state == S_IDLE);
    out_valid = (state == S_OUT);
  end

  // result preset while idle: done for clear, not found otherwise
  out_item_t idle_out;
  always_comb begin
    idle_out = '0;
    idle_out.status = (in_valid && in_data.cmd == CMD_CLEAR) ? ST_DONE : ST_NOT_FOUND;
  end

  // shared compare unit results for the current index
  logic hit_real, free_real, hit_virt;
  assign hit_real = in_use && slot_active[si] && slot_ident[si] == cur.voice_id;
  assign free_real = in_use && !slot_active[si];
  assign hit_virt = virt_valid[vi] && virt_ident[vi] == cur.voice_id;
  logic [31:0] age_d;
  assign age_d = age_clock - slot_age[si];

  // virtualization decision after the multiply cycle
  logic virt_ok;
  assign virt_ok = qhit && (vcap != '0) && ({1'b0, vcount} < vcap) &&
                   (slot_spatial[qidx] ? (prod < {1'b0, virtual_threshold, 15'b0})
                                       : (slot_volume[qidx] < virtual_threshold));

  // result fields for a real slot or a virtual entry
  function automatic out_item_t rep_real(input out_item_t o, input logic [3:0] i4,
                                         input logic [31:0] id, input logic [15:0] vo,
                                         input logic [15:0] g, input logic p,
                                         input logic s);
    out_item_t r;
    r = o;
    r.slot_index = i4; r.result_id = id; r.found_volume = vo; r.found_gain = g;
    r.found_protect = p; r.found_spatial = s;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_voices <= 5'd16;
      max_virtual <= '0;
      virtual_threshold <= '0;
      slot_active <= '0; slot_protect <= '0; slot_spatial <= '0;
      virt_valid <= '0;
      next_ident <= '0; age_clock <= '0;
      idx <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        slot_ident[k] <= '0; slot_age[k] <= '0;
        slot_volume[k] <= UNITY; slot_gain[k] <= UNITY;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_VOICES: max_voices <= cfg_data[4:0];
          CFG_MAX_VIRT:   max_virtual <= cfg_data[4:0];
          CFG_THRESH:     virtual_threshold <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          idx <= '0;
          cur <= in_data;
          rhit <= 1'b0; rfree <= 1'b0; vhit <= 1'b0; vfree <= 1'b0;
          qhit <= 1'b0; ohit <= 1'b0; vcount <= '0;
          ridx <= '0; fidx <= '0; vidx <= '0; eidx <= VW'(VIRTUAL_SLOTS - 1);
          qidx <= '0; oidx <= '0; qvol <= '0; obest <= '0;
          out_data <= idle_out;
          if (in_valid && in_data.cmd == CMD_CLEAR) begin
            slot_active <= '0; slot_protect <= '0; slot_spatial <= '0;
            for (int k = 0; k < SLOTS; k++) begin
              slot_ident[k] <= '0; slot_age[k] <= '0;
              slot_volume[k] <= UNITY; slot_gain[k] <= UNITY;
            end
          end
        end
        S_SCAN_REAL: begin
          if (hit_real && !rhit) begin rhit <= 1'b1; ridx <= si; end
          if (free_real && !rfree) begin rfree <= 1'b1; fidx <= si; end
          idx <= last_real ? '0 : idx + 1'b1;
        end
        S_SCAN_VIRT: begin
          if (hit_virt && !vhit) begin vhit <= 1'b1; vidx <= vi; end
          if (!virt_valid[vi] && !vfree) begin vfree <= 1'b1; eidx <= vi; end
          vcount <= vcount + CW'(virt_valid[vi]);
          idx <= last_virt ? '0 : idx + 1'b1;
        end
        S_SCAN_QUIET: begin
          if (in_use && slot_active[si] && !slot_protect[si] &&
              (!qhit || slot_volume[si] < qvol)) begin
            qhit <= 1'b1; qidx <= si; qvol <= slot_volume[si];
          end
          idx <= last_real ? '0 : idx + 1'b1;
        end
        S_MUL: prod <= 32'(slot_volume[qidx]) * 32'(slot_gain[qidx]);
        S_SCAN_OLD: begin
          if (in_use && !slot_protect[si] && (!ohit || age_d > obest)) begin
            ohit <= 1'b1; oidx <= si; obest <= age_d;
          end
          idx <= last_real ? '0 : idx + 1'b1;
        end
        default: ;
      endcase

      // commit at the end of the last scan
      if ((state == S_SCAN_REAL && last_real && cur.cmd == CMD_FREE) ||
          (state == S_SCAN_VIRT && last_virt) ||
          (state == S_SCAN_OLD && last_real)) begin : commit
        logic rh, vh, fr;
        logic [SW-1:0] ri, fi;
        logic [VW-1:0] vx;
        out_item_t o;
        rh = rhit || hit_real && state == S_SCAN_REAL;
        ri = rhit ? ridx : si;
        vh = vhit || hit_virt && state == S_SCAN_VIRT;
        vx = vhit ? vidx : vi;
        fr = rfree;
        fi = fidx;
        o = '0;
        o.status = ST_NOT_FOUND;
        case (cur.cmd)
          CMD_FREE: if (rh) begin
            slot_active[ri] <= 1'b0;
            o.status = ST_DONE; o.slot_index = 4'(ri);
          end
          CMD_FREE_VIRT: if (vh) begin
            virt_valid[vx] <= 1'b0;
            o.status = ST_DONE; o.slot_index = 4'(vx);
          end
          CMD_FIND, CMD_SET: begin
            if (rhit) begin
              if (cur.cmd == CMD_SET) begin
                slot_volume[ridx] <= sat_q15(cur.new_volume);
                slot_gain[ridx] <= sat_q15(cur.new_gain);
                slot_protect[ridx] <= cur.new_protect;
                slot_spatial[ridx] <= cur.new_spatial;
                o = rep_real(o, 4'(ridx), slot_ident[ridx], sat_q15(cur.new_volume),
                             sat_q15(cur.new_gain), cur.new_protect, cur.new_spatial);
              end else begin
                o = rep_real(o, 4'(ridx), slot_ident[ridx], slot_volume[ridx],
                             slot_gain[ridx], slot_protect[ridx], slot_spatial[ridx]);
              end
              o.status = (cur.cmd == CMD_FIND) ? ST_FOUND : ST_DONE;
            end else if (vh) begin
              if (cur.cmd == CMD_SET) begin
                virt_volume[vx] <= sat_q15(cur.new_volume);
                virt_gain[vx] <= sat_q15(cur.new_gain);
                virt_flags[vx] <= {cur.new_spatial, cur.new_protect};
                o = rep_real(o, 4'(vx), virt_ident[vx], sat_q15(cur.new_volume),
                             sat_q15(cur.new_gain), cur.new_protect, cur.new_spatial);
              end else begin
                o = rep_real(o, 4'(vx), virt_ident[vx], virt_volume[vx], virt_gain[vx],
                             virt_flags[vx][0], virt_flags[vx][1]);
              end
              o.in_virtual = 1'b1;
              o.status = (cur.cmd == CMD_FIND) ? ST_FOUND : ST_DONE;
            end
          end
          CMD_REACT: if (vh) begin
            if (!fr) o.status = ST_NO_FREE;
            else begin
              slot_active[fi] <= 1'b1;
              slot_ident[fi] <= virt_ident[vx];
              slot_volume[fi] <= virt_volume[vx];
              slot_gain[fi] <= virt_gain[vx];
              slot_protect[fi] <= virt_flags[vx][0];
              slot_spatial[fi] <= virt_flags[vx][1];
              slot_age[fi] <= age_clock;
              age_clock <= age_clock + 32'd1;
              virt_valid[vx] <= 1'b0;
              o = rep_real(o, 4'(fi), virt_ident[vx], virt_volume[vx], virt_gain[vx],
                           virt_flags[vx][0], virt_flags[vx][1]);
              o.status = ST_DONE;
            end
          end
          CMD_ALLOC: begin
            if (fr || state == S_SCAN_OLD) begin : place
              logic [SW-1:0] t;
              logic take;
              take = 1'b1;
              t = fi;
              o.status = ST_FREE_SLOT;
              if (!fr) begin
                if (virt_ok) begin
                  t = qidx;
                  o.status = ST_VIRTUALIZED;
                  virt_valid[eidx] <= 1'b1;
                  virt_ident[eidx] <= slot_ident[qidx];
                  virt_volume[eidx] <= slot_volume[qidx];
                  virt_gain[eidx] <= slot_gain[qidx];
                  virt_flags[eidx] <= {slot_spatial[qidx], slot_protect[qidx]};
                  o.displaced_id = slot_ident[qidx];
                end else if (ohit || (in_use && !slot_protect[si])) begin
                  t = (!ohit || (in_use && !slot_protect[si] && age_d > obest)) ? si : oidx;
                  o.status = ST_STOLEN;
                  o.displaced_id = slot_ident[t];
                end else begin
                  take = 1'b0;
                  o.status = ST_ALL_PROT;
                end
              end
              if (take) begin
                slot_active[t] <= 1'b1; slot_protect[t] <= 1'b0;
                slot_spatial[t] <= 1'b0;
                slot_ident[t] <= next_ident; slot_age[t] <= age_clock;
                slot_volume[t] <= UNITY; slot_gain[t] <= UNITY;
                next_ident <= next_ident + 32'd1;
                age_clock <= age_clock + 32'd1;
                o = rep_real(o, 4'(t), next_ident, UNITY, UNITY, 1'b0, 1'b0);
              end
            end
          end
          default: ;
        endcase
        if (!(cur.cmd == CMD_ALLOC && !rfree && state == S_SCAN_VIRT)) out_data <= o;
      end
    end
  end

  // busy after a command is taken, never open on both sides, result held while stalled
  `VSA_ASSERT_NEXT(a_in_then_busy, in_valid && in_ready, !in_ready,
                   "block ready right after a transfer")
  `VSA_ASSERT_IMPL(a_one_side, out_valid, !in_ready,
                   "input and output open at once")
  `VSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data),
                   "result changed while stalled")
endmodule
`default_nettype wire

// File: sim/testbench.sv
// self-checking testbench for voice_slot_allocator
// depends on vsa_pkg and the allocator rtl; holds its own voice pool predictor
`default_nettype none
module testbench;
  import vsa_pkg::*;

  // predictor of the voice pool plus the queue of expected results
  class voice_scoreboard;
    logic        act [16];
    logic        prot [16];
    logic [31:0] ident [16];
    logic [31:0] age [16];
    logic [15:0] vol [16];
    logic [15:0] gain [16];
    logic        spat [16];
    logic        vvalid [16];
    logic [31:0] vident [16];
    logic [15:0] vvol [16];
    logic [15:0] vgain [16];
    logic [1:0]  vflags [16];
    logic [31:0] next_id;
    logic [31:0] age_clk;
    logic [4:0]  voices_cfg;
    logic [4:0]  virt_cfg;
    logic [15:0] thresh_cfg;
    out_item_t   pending_results[$];
    int          errors;
    int          checked;
    int          status_seen [8];

    function void reset_state();
      for (int i = 0; i < 16; i++) begin
        default_slot(i);
        vvalid[i] = 0;
        vident[i] = '0;
        vvol[i] = '0;
        vgain[i] = '0;
        vflags[i] = '0;
      end
      next_id = '0;
      age_clk = '0;
      voices_cfg = 5'd16;
      virt_cfg = 5'd0;
      thresh_cfg = 16'd0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == CFG_MAX_VOICES) voices_cfg = val[4:0];
      else if (idx == CFG_MAX_VIRT) virt_cfg = val[4:0];
      else if (idx == CFG_THRESH) thresh_cfg = val;
    endfunction

    function void default_slot(int i);
      act[i] = 0;
      prot[i] = 0;
      ident[i] = '0;
      age[i] = '0;
      vol[i] = UNITY;
      gain[i] = UNITY;
      spat[i] = 0;
    endfunction

    function int live_slots();
      return (voices_cfg > 16) ? 16 : int'(voices_cfg);
    endfunction

    function void fresh_voice(int i);
      default_slot(i);
      act[i] = 1;
      ident[i] = next_id;
      next_id = next_id + 1;
      age[i] = age_clk;
      age_clk = age_clk + 1;
    endfunction

    function int real_of(logic [31:0] id);
      for (int i = 0; i < live_slots(); i++)
        if (act[i] && ident[i] == id) return i;
      return -1;
    endfunction

    function int virt_of(logic [31:0] id);
      for (int i = 0; i < 16; i++)
        if (vvalid[i] && vident[i] == id) return i;
      return -1;
    endfunction

    function int first_idle();
      for (int i = 0; i < live_slots(); i++)
        if (!act[i]) return i;
      return -1;
    endfunction

    function void fill_real(ref out_item_t r, input int i);
      r.slot_index = i[3:0];
      r.result_id = ident[i];
      r.found_volume = vol[i];
      r.found_gain = gain[i];
      r.found_protect = prot[i];
      r.found_spatial = spat[i];
    endfunction

    // allocation: free slot, then virtualize the quietest, then steal the oldest
    function void allocate(ref out_item_t r);
      int i, q, v, e, cnt, cap;
      logic below;
      logic [31:0] d, best;
      i = first_idle();
      if (i >= 0) begin
        fresh_voice(i);
        fill_real(r, i);
        r.status = ST_FREE_SLOT;
        return;
      end
      cap = (virt_cfg > 16) ? 16 : int'(virt_cfg);
      cnt = 0;
      for (int k = 0; k < 16; k++) cnt += vvalid[k];
      if (cap > 0 && cnt < cap) begin
        q = -1;
        for (int k = 0; k < live_slots(); k++) begin
          if (!act[k] || prot[k]) continue;
          if (q < 0 || vol[k] < vol[q]) q = k;
        end
        if (q >= 0) begin
          if (spat[q]) below = (64'(vol[q]) * 64'(gain[q])) < (64'(thresh_cfg) << 15);
          else below = vol[q] < thresh_cfg;
          if (below) begin
            e = 0;
            while (e < 15 && vvalid[e]) e++;
            vvalid[e] = 1;
            vident[e] = ident[q];
            vvol[e] = vol[q];
            vgain[e] = gain[q];
            vflags[e] = {spat[q], prot[q]};
            r.displaced_id = ident[q];
            fresh_voice(q);
            fill_real(r, q);
            r.status = ST_VIRTUALIZED;
            return;
          end
        end
      end
      v = -1;
      best = '0;
      for (int k = 0; k < live_slots(); k++) begin
        if (prot[k]) continue;
        d = age_clk - age[k];
        if (v < 0 || d > best) begin
          v = k;
          best = d;
        end
      end
      if (v < 0) begin
        r.status = ST_ALL_PROT;
        return;
      end
      r.displaced_id = ident[v];
      fresh_voice(v);
      fill_real(r, v);
      r.status = ST_STOLEN;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      int i, k;
      logic [15:0] nv, ng;
      r = '0;
      r.status = ST_NOT_FOUND;
      nv = (it.new_volume > UNITY) ? UNITY : it.new_volume;
      ng = (it.new_gain > UNITY) ? UNITY : it.new_gain;
      case (cmd_t'(it.cmd))
        CMD_CLEAR: begin
          for (int s = 0; s < 16; s++) default_slot(s);
          r.status = ST_DONE;
        end
        CMD_ALLOC: allocate(r);
        CMD_FREE: begin
          i = real_of(it.voice_id);
          if (i >= 0) begin
            act[i] = 0;
            r.slot_index = i[3:0];
            r.status = ST_DONE;
          end
        end
        CMD_FREE_VIRT: begin
          i = virt_of(it.voice_id);
          if (i >= 0) begin
            vvalid[i] = 0;
            r.slot_index = i[3:0];
            r.status = ST_DONE;
          end
        end
        CMD_FIND, CMD_SET: begin
          i = real_of(it.voice_id);
          if (i >= 0) begin
            if (it.cmd == CMD_SET) begin
              vol[i] = nv;
              gain[i] = ng;
              prot[i] = it.new_protect;
              spat[i] = it.new_spatial;
            end
            fill_real(r, i);
            r.status = (it.cmd == CMD_FIND) ? ST_FOUND : ST_DONE;
          end else begin
            i = virt_of(it.voice_id);
            if (i >= 0) begin
              if (it.cmd == CMD_SET) begin
                vvol[i] = nv;
                vgain[i] = ng;
                vflags[i] = {it.new_spatial, it.new_protect};
              end
              r.slot_index = i[3:0];
              r.result_id = vident[i];
              r.found_volume = vvol[i];
              r.found_gain = vgain[i];
              r.found_protect = vflags[i][0];
              r.found_spatial = vflags[i][1];
              r.in_virtual = 1;
              r.status = (it.cmd == CMD_FIND) ? ST_FOUND : ST_DONE;
            end
          end
        end
        CMD_REACT: begin
          i = virt_of(it.voice_id);
          if (i >= 0) begin
            k = first_idle();
            if (k < 0) r.status = ST_NO_FREE;
            else begin
              default_slot(k);
              act[k] = 1;
              ident[k] = vident[i];
              vol[k] = vvol[i];
              gain[k] = vgain[i];
              prot[k] = vflags[i][0];
              spat[k] = vflags[i][1];
              age[k] = age_clk;
              age_clk = age_clk + 1;
              vvalid[i] = 0;
              fill_real(r, k);
              r.status = ST_DONE;
            end
          end
        end
        default: ;
      endcase
      pending_results = {pending_results, r};
    endfunction

    function void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_results.size() == 0) begin
        $display("%0t mismatch: unexpected result, expected none actual %0h", $time, got);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      checked++;
      status_seen[e.status]++;
      field_check("status", 32'(e.status), 32'(got.status));
      field_check("slot_index", 32'(e.slot_index), 32'(got.slot_index));
      field_check("result_id", e.result_id, got.result_id);
      field_check("displaced_id", e.displaced_id, got.displaced_id);
      field_check("found_volume", 32'(e.found_volume), 32'(got.found_volume));
      field_check("found_gain", 32'(e.found_gain), 32'(got.found_gain));
      field_check("found_protect", 32'(e.found_protect), 32'(got.found_protect));
      field_check("found_spatial", 32'(e.found_spatial), 32'(got.found_spatial));
      field_check("in_virtual", 32'(e.in_virtual), 32'(got.in_virtual));
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int PHASE_ITEMS = 200;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  voice_scoreboard pool;
  int  idle_cycles;
  int  cycle_count;
  int  sent;
  int  burst_left;

  voice_slot_allocator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // one command transfer; called and returns at a falling edge
  task automatic send_cmd(input in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 14);
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
    burst_left--;
    in_data = it;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    pool.note_input(in_data);
    sent++;
    @(negedge clk);
  endtask

  function automatic in_item_t make_cmd(cmd_t c, logic [31:0] id, logic [15:0] v,
                                        logic [15:0] g, logic p, logic s);
    in_item_t it;
    it.cmd = c;
    it.voice_id = id;
    it.new_volume = v;
    it.new_gain = g;
    it.new_protect = p;
    it.new_spatial = s;
    return it;
  endfunction

  // ids mostly near the live range so commands hit real and virtual voices
  function automatic in_item_t random_cmd();
    in_item_t it;
    int pick;
    it.voice_id = ($urandom_range(0, 9) == 0) ? $urandom() :
                  pool.next_id - $urandom_range(1, 28);
    it.new_volume = ($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768));
    it.new_gain = ($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768));
    it.new_protect = ($urandom_range(0, 4) == 0);
    it.new_spatial = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 2) it.cmd = CMD_CLEAR;
    else if (pick < 36) it.cmd = CMD_ALLOC;
    else if (pick < 47) it.cmd = CMD_FREE;
    else if (pick < 54) it.cmd = CMD_FREE_VIRT;
    else if (pick < 65) it.cmd = CMD_FIND;
    else if (pick < 75) it.cmd = CMD_REACT;
    else if (pick < 98) it.cmd = CMD_SET;
    else it.cmd = CMD_NONE;
    return it;
  endfunction

  // register writes only once every result is back
  task automatic write_cfg(input logic [4:0] voices, input logic [4:0] virt,
                           input logic [15:0] thresh);
    in_valid = 0;
    while (pool.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    for (int r = 0; r < 3; r++) begin
      cfg_we = 1;
      cfg_index = 2'(r);
      cfg_data = (r == 0) ? 16'(voices) : (r == 1) ? 16'(virt) : thresh;
      pool.set_reg(cfg_index, cfg_data);
      @(negedge clk);
    end
    cfg_we = 0;
  endtask

  // receiver: own stall pattern plus one long hold-off to back up the input
  initial begin
    int mode;
    int rx_cycles;
    out_ready = 0;
    mode = 0;
    rx_cycles = 0;
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (rx_cycles % 64 == 0) mode = $urandom_range(0, 2);
      if (rx_cycles >= 4000 && rx_cycles < 4400) out_ready = 0;
      else if (mode == 0) out_ready = 1;
      else if (mode == 1) out_ready = $urandom_range(0, 1);
      else out_ready = ($urandom_range(0, 7) == 0);
    end
  end

  // result transfers and the watchdog
  initial begin
    idle_cycles = 0;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (!rst && out_valid && out_ready) pool.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int guard;
    pool = new();
    pool.reset_state();
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    sent = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: four slots, two virtual entries, threshold at unity
    write_cfg(5'd4, 5'd2, 16'h8000);
    repeat (4) send_cmd(make_cmd(CMD_ALLOC, '0, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(CMD_SET, 32'd0, 16'h7fff, 16'hffff, 1'b0, 1'b1));
    send_cmd(make_cmd(CMD_SET, 32'd1, 16'hffff, 16'h0000, 1'b0, 1'b0));
    send_cmd(make_cmd(CMD_SET, 32'd2, 16'h0000, 16'h8000, 1'b1, 1'b1));
    send_cmd(make_cmd(CMD_ALLOC, '0, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(CMD_FIND, 32'd0, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(CMD_FIND, 32'hffffffff, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(CMD_REACT, 32'd0, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(CMD_FREE, 32'd3, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(CMD_SET, 32'd0, 16'h1234, 16'h4321, 1'b1, 1'b0));
    send_cmd(make_cmd(CMD_REACT, 32'd0, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(CMD_ALLOC, '0, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(CMD_FREE_VIRT, 32'd4, '0, '0, 1'b0, 1'b0));
    for (int i = 0; i < 7; i++)
      send_cmd(make_cmd(CMD_SET, 32'd0 + i, 16'h8000, 16'h8000, 1'b1, 1'b0));
    send_cmd(make_cmd(CMD_ALLOC, '0, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(CMD_NONE, 32'd1, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(CMD_CLEAR, '0, '0, '0, 1'b0, 1'b0));

    // random phases over a spread of settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_cfg(5'd16, 5'd0, 16'd0);
        1: write_cfg(5'd1, 5'd16, 16'hffff);
        2: write_cfg(5'd31, 5'd31, 16'h8000);
        3: write_cfg(5'd4, 5'd3, 16'h4000);
        4: write_cfg(5'd0, 5'd1, 16'h0001);
        5: write_cfg(5'd16, 5'd16, 16'h8000);
        6: write_cfg(5'd8, 5'd2, 16'h2000);
        default: write_cfg(5'($urandom_range(1, 16)), 5'($urandom_range(0, 16)),
                           16'($urandom_range(0, 32768)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_cmd(random_cmd());
    end

    in_valid = 0;
    guard = 0;
    while (pool.pending_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (100) @(negedge clk);
    if (pool.pending_results.size() != 0) begin
      $display("%0d results never arrived", pool.pending_results.size());
      pool.errors++;
    end
    $display("sent %0d commands over 9 settings, checked %0d results", sent, pool.checked);
    $display("allocs: %0d free slot, %0d virtualized, %0d stolen, %0d all protected",
             pool.status_seen[ST_FREE_SLOT], pool.status_seen[ST_VIRTUALIZED],
             pool.status_seen[ST_STOLEN], pool.status_seen[ST_ALL_PROT]);
    if (pool.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
